/* hdl/assert_macros.svh */
// Assertion macros shared by the detection candidate decode RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define DCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dcd assertion failed");
// Condition that must never be true outside reset.
`define DCD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dcd forbidden condition seen");
`else
`define DCD_ASSERT(lbl, clk, rst_n, prop)
`define DCD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hdl/dcd_pkg.sv */
`timescale 1ns / 1ps
// Package for the detection candidate decode: widths, register codes,
// row job and divider handshake types. No dependencies.
package dcd_pkg;

    // Field widths.
    localparam int VALUE_W    = 22;
    localparam int CLASS_W    = 8;
    localparam int BOX_W      = 14;
    localparam int THR_W      = 11;
    localparam int FRAME_W    = 13;
    localparam int INSZ_W     = 12;

    // Row layout and position counter.
    localparam int POS_W           = 9;
    localparam int POS_MAX         = 511;
    localparam int NUM_BOX         = 4;
    localparam int BOX_IDX_W       = 2;
    localparam int FIRST_CLASS     = 5;
    localparam int NUM_CLASSES_DEF = 80;

    // Arithmetic widths and shifts.
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int CONF_FRAC   = 10;
    localparam int NUM_W       = 38;
    localparam int MAG_W       = 25;
    localparam int EDGE_SHIFT  = 11;
    localparam int EXT_SHIFT   = 10;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 88;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Register reset values.
    localparam logic [THR_W-1:0]   THR_RESET     = 11'd256;
    localparam logic [FRAME_W-1:0] FRAME_W_RESET = 13'd1920;
    localparam logic [FRAME_W-1:0] FRAME_H_RESET = 13'd1080;
    localparam logic [INSZ_W-1:0]  INSZ_RESET    = 12'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_FRAME_WID = 2'd1,
        REG_FRAME_HGT = 2'd2,
        REG_NET_SIZE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [INSZ_W-1:0]  net_size;
    } cfg_t;

    // One complete candidate row handed from front to back.
    typedef struct packed {
        logic signed [VALUE_W-1:0] box_cx;
        logic signed [VALUE_W-1:0] box_cy;
        logic signed [VALUE_W-1:0] box_bw;
        logic signed [VALUE_W-1:0] box_bh;
        logic signed [VALUE_W-1:0] obj;
        logic signed [VALUE_W-1:0] best;
        logic [CLASS_W-1:0]        best_index;
    } row_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHECK,
        BK_PREP,
        BK_DIV_START,
        BK_DIV_WAIT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  dividend;
        logic [INSZ_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MAG_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* hdl/dcd_front.sv */
`timescale 1ns / 1ps
// Front end of the decode: tracks the row position, keeps box values and
// objectness, runs the class argmax and issues one job per full row. Uses dcd_pkg.
module dcd_front #(
    parameter int NUM_CLASSES = dcd_pkg::NUM_CLASSES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [dcd_pkg::VALUE_W-1:0]  in_value,
    input  logic                                in_last,
    input  logic                                in_valid,
    output logic                                in_ready,
    output dcd_pkg::row_job_t                   job_data,
    output logic                                job_valid,
    input  logic                                job_ready
);
    import dcd_pkg::*;

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic signed [VALUE_W-1:0] box_reg [NUM_BOX];
    logic signed [VALUE_W-1:0] box_next [NUM_BOX];
    logic signed [VALUE_W-1:0] obj_reg, obj_next;
    logic signed [VALUE_W-1:0] best_reg, best_next;
    logic [CLASS_W-1:0]        idx_reg, idx_next;
    logic [POS_W-1:0]          cls;
    logic                      accept;

    // An item is only taken when the queue can hold a finished row.
    assign in_ready = job_ready;
    assign accept   = in_valid && job_ready;
    assign cls      = pos_reg - POS_W'(FIRST_CLASS);

    // Classify the item by its row position and update the kept values.
    always_comb begin
        pos_next  = pos_reg;
        box_next  = box_reg;
        obj_next  = obj_reg;
        best_next = best_reg;
        idx_next  = idx_reg;
        if (accept) begin
            if (pos_reg < POS_W'(NUM_BOX)) begin
                box_next[pos_reg[BOX_IDX_W-1:0]] = in_value;
            end else if (pos_reg == POS_W'(NUM_BOX)) begin
                obj_next = in_value;
            end else if (cls < POS_W'(NUM_CLASSES)) begin
                // The first class always loads; later ones only on a strict win.
                if (cls == '0 || in_value > best_reg) begin
                    best_next = in_value;
                    idx_next  = cls[CLASS_W-1:0];
                end
            end
            if (in_last) begin
                pos_next = '0;
            end else if (pos_reg != POS_W'(POS_MAX)) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // A row ending with at least one class score becomes a job.
    assign job_valid = accept && in_last && (pos_reg >= POS_W'(FIRST_CLASS));

    always_comb begin
        job_data.box_cx     = box_next[0];
        job_data.box_cy     = box_next[1];
        job_data.box_bw     = box_next[2];
        job_data.box_bh     = box_next[3];
        job_data.obj        = obj_next;
        job_data.best       = best_next;
        job_data.best_index = idx_next;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            idx_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            idx_reg <= idx_next;
        end
    end

    // Row payload.
    always_ff @(posedge aclk) begin
        box_reg  <= box_next;
        obj_reg  <= obj_next;
        best_reg <= best_next;
    end

endmodule

/* hdl/dcd_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front and back ends of the decode.
// Uses dcd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dcd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  dcd_pkg::row_job_t push_data,
    input  logic              push_valid,
    output logic              push_ready,
    output dcd_pkg::row_job_t pop_data,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import dcd_pkg::*;

    row_job_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `DCD_ASSERT_NEVER(a_q_overflow, aclk, aresetn, push_valid && !push_ready)
    `DCD_ASSERT(a_q_count_range, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `DCD_ASSERT(a_q_ptr_match, aclk, aresetn, (wr_ptr_reg == rd_ptr_reg) == (!pop_valid || !push_ready))

endmodule

/* hdl/dcd_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle, for box scaling.
// Uses dcd_pkg.
module dcd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  dcd_pkg::div_req_t req,
    output dcd_pkg::div_rsp_t rsp
);
    import dcd_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [INSZ_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [INSZ_W-1:0] dvs_reg, dvs_next;
    logic [INSZ_W:0]   rem_shift;
    logic [INSZ_W:0]   rem_diff;
    logic              step_bit;

    // One trial subtraction per cycle.
    assign rem_shift = {rem_reg, quo_reg[MAG_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign step_bit  = (rem_shift >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[MAG_W-2:0], step_bit};
            rem_next = step_bit ? rem_diff[INSZ_W-1:0] : rem_shift[INSZ_W-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* hdl/dcd_back.sv */
`timescale 1ns / 1ps
// Back end of the decode: confidence, threshold tests, box scaling through
// the shared divider, and the output register. Uses dcd_pkg, dcd_div, assert_macros.svh.
`include "assert_macros.svh"
module dcd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dcd_pkg::cfg_t                     cfg,
    input  dcd_pkg::row_job_t                 job_data,
    input  logic                              job_valid,
    output logic                              job_ready,
    output logic [dcd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import dcd_pkg::*;

    back_state_t               state_reg, state_next;
    row_job_t                  job_reg, job_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [VALUE_W-1:0] conf_reg, conf_next, conf_sat;
    logic signed [VALUE_W-1:0] thr_s;
    logic                      pass;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic [BOX_IDX_W-1:0]      k_reg, k_next;
    logic [BOX_W-1:0]          box_reg [NUM_BOX];
    logic [BOX_W-1:0]          box_next [NUM_BOX];
    logic                      out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]      out_data_reg, out_data_next;
    logic                      out_load;
    logic                      is_edge;
    logic signed [VALUE_W-1:0] sel_c, sel_s;
    logic signed [VALUE_W+1:0] c_ext, s_ext, term;
    logic [FRAME_W-1:0]        sel_frame;
    logic signed [FRAME_W:0]   frame_s;
    logic                      num_neg;
    logic [NUM_W-1:0]          num_mag, mag_sh;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    // Truncated quotient magnitude with its sign, saturated to a box field.
    function automatic logic [BOX_W-1:0] sat_box(input logic neg, input logic [MAG_W-1:0] mag);
        logic [BOX_W-1:0] r;
        if (neg) begin
            if (mag > MAG_W'(2 ** (BOX_W - 1))) begin
                r = {1'b1, {(BOX_W-1){1'b0}}};
            end else begin
                r = BOX_W'(MAG_W'(0) - mag);
            end
        end else if (mag > MAG_W'(2 ** (BOX_W - 1) - 1)) begin
            r = {1'b0, {(BOX_W-1){1'b1}}};
        end else begin
            r = mag[BOX_W-1:0];
        end
        return r;
    endfunction

    // Confidence: floor of the product over 1024, saturated to 22 bits.
    assign prod_sh = prod_reg >>> CONF_FRAC;
    always_comb begin
        if (!prod_sh[PROD_W-1] && (|prod_sh[PROD_W-2:VALUE_W-1])) begin
            conf_sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end else if (prod_sh[PROD_W-1] && !(&prod_sh[PROD_W-2:VALUE_W-1])) begin
            conf_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            conf_sat = prod_sh[VALUE_W-1:0];
        end
    end

    assign thr_s = $signed({{(VALUE_W-THR_W){1'b0}}, cfg.threshold});
    assign pass  = (job_reg.obj >= thr_s) && (conf_sat >= thr_s);

    // Operand selection: the first two steps give edges, the last two extents.
    assign is_edge   = !k_reg[1];
    assign sel_c     = k_reg[0] ? job_reg.box_cy : job_reg.box_cx;
    assign sel_s     = k_reg[0] ? job_reg.box_bh : job_reg.box_bw;
    assign sel_frame = k_reg[0] ? cfg.frame_height : cfg.frame_width;
    assign frame_s   = $signed({1'b0, sel_frame});
    assign c_ext     = (VALUE_W+2)'(sel_c);
    assign s_ext     = (VALUE_W+2)'(sel_s);
    assign term      = is_edge ? (c_ext <<< 1) - s_ext : s_ext;

    // Magnitude of the scaled numerator, pre-divided by the power-of-two part.
    assign num_neg = num_reg[NUM_W-1];
    assign num_mag = num_neg ? unsigned'(-num_reg) : unsigned'(num_reg);
    assign mag_sh  = is_edge ? (num_mag >> EDGE_SHIFT) : (num_mag >> EXT_SHIFT);

    assign div_req.start    = (state_reg == BK_DIV_START);
    assign div_req.dividend = mag_sh[MAG_W-1:0];
    assign div_req.divisor  = (cfg.net_size == '0) ? INSZ_W'(1) : cfg.net_size;

    dcd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:      if (job_valid) state_next = BK_MUL;
            BK_MUL:       state_next = BK_CHECK;
            BK_CHECK:     state_next = pass ? BK_PREP : BK_IDLE;
            BK_PREP:      state_next = BK_DIV_START;
            BK_DIV_START: state_next = BK_DIV_WAIT;
            BK_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (k_reg == BOX_IDX_W'(NUM_BOX - 1)) ? BK_EMIT : BK_PREP;
                end
            end
            BK_EMIT:      if (!out_valid_reg || m_tready) state_next = BK_IDLE;
            default:      state_next = BK_IDLE;
        endcase
    end

    // Datapath and handshake outputs per state.
    always_comb begin
        job_ready = 1'b0;
        out_load  = 1'b0;
        job_next  = job_reg;
        prod_next = prod_reg;
        conf_next = conf_reg;
        num_next  = num_reg;
        k_next    = k_reg;
        box_next  = box_reg;
        case (state_reg)
            BK_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) job_next = job_data;
            end
            BK_MUL: begin
                prod_next = $signed(job_reg.best) * $signed(job_reg.obj);
            end
            BK_CHECK: begin
                conf_next = conf_sat;
                k_next    = '0;
            end
            BK_PREP: begin
                num_next = term * frame_s;
            end
            BK_DIV_WAIT: begin
                if (div_rsp.done) begin
                    box_next[k_reg] = sat_box(num_neg, div_rsp.quotient);
                    k_next          = k_reg + 1'b1;
                end
            end
            BK_EMIT: begin
                out_load = !out_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    // Output register: a finished result waits here while the next row runs.
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);
    assign out_data_next  = out_load ?
        {2'b00, box_reg[3], box_reg[2], box_reg[1], box_reg[0], conf_reg,
         job_reg.best_index} : out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        prod_reg     <= prod_next;
        conf_reg     <= conf_next;
        num_reg      <= num_next;
        box_reg      <= box_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `DCD_ASSERT(a_div_start_free, aclk, aresetn, div_req.start |-> !div_rsp.busy)
    `DCD_ASSERT(a_out_no_overwrite, aclk, aresetn, out_load |-> (!out_valid_reg || m_tready))
    `DCD_ASSERT(a_div_done_waiting, aclk, aresetn, div_rsp.done |-> (state_reg == BK_DIV_WAIT))

endmodule

/* hdl/detection_candidate_decode.sv */
`timescale 1ns / 1ps
// Top level of the detection candidate decode: configuration registers,
// front end, job queue and back end. Uses dcd_pkg, dcd_front, dcd_queue, dcd_back.
//
//  Channel  Ports                        Transaction contents
//  input    s_tvalid/s_tready/s_tdata    tdata: value[21:0]; tlast: row_end
//  result   m_tvalid/m_tready/m_tdata    tdata: class_id, confidence, box x/y/w/h
//  config   cfg_we/cfg_index/cfg_data    one register write per asserted cycle
//
// The front takes one tensor value per cycle while the two-entry job queue has room.
// A row that passes the thresholds runs the idle, multiply and check steps in the back end,
// then for each of the four box fields a setup step, a start step and a wait on the shared
// divider, and last the emit step, which loads its result.
// A row that fails either threshold returns the back end to idle after the check step.
// Reset is synchronous; no clearing pass follows it.
// A stalled result sits in the output register while the back end starts the next row.
module detection_candidate_decode #(
    parameter int NUM_CLASSES = dcd_pkg::NUM_CLASSES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata fields from bit 0: value (22 bits), zero fill (2 bits)
    input  logic [dcd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata fields from bit 0: class_id (8), confidence (22), box_x (14),
    // box_y (14), box_w (14), box_h (14), zero fill (2)
    output logic [dcd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [dcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dcd_pkg::*;

    cfg_t     cfg_reg;
    row_job_t front_job;
    logic     front_job_valid;
    logic     front_job_ready;
    row_job_t back_job;
    logic     back_job_valid;
    logic     back_job_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold    <= THR_RESET;
            cfg_reg.frame_width  <= FRAME_W_RESET;
            cfg_reg.frame_height <= FRAME_H_RESET;
            cfg_reg.net_size     <= INSZ_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:  cfg_reg.threshold    <= cfg_data[THR_W-1:0];
                REG_FRAME_WID:  cfg_reg.frame_width  <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HGT:  cfg_reg.frame_height <= cfg_data[FRAME_W-1:0];
                REG_NET_SIZE:   cfg_reg.net_size     <= cfg_data[INSZ_W-1:0];
                default: ;
            endcase
        end
    end

    dcd_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_value  ($signed(s_tdata[VALUE_W-1:0])),
        .in_last   (s_tlast),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .job_data  (front_job),
        .job_valid (front_job_valid),
        .job_ready (front_job_ready)
    );

    dcd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (front_job),
        .push_valid (front_job_valid),
        .push_ready (front_job_ready),
        .pop_data   (back_job),
        .pop_valid  (back_job_valid),
        .pop_ready  (back_job_ready)
    );

    dcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_data  (back_job),
        .job_valid (back_job_valid),
        .job_ready (back_job_ready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule
